@@ src/spt3d_pkg.sv @@
package spt3d_pkg;

    localparam int NBR_COUNT    = 26;
    localparam int NBR18_COUNT  = 18;
    localparam int FACE_COUNT   = 6;
    localparam int COUNT_W      = 5;
    localparam int DIR_W        = 3;
    // 4 growth steps per stage, 7 stages: 28 steps cover the longest path (25)
    localparam int FLOOD_STEPS  = 4;
    localparam int FLOOD_STAGES = 7;

    typedef logic [NBR_COUNT-1:0]   t_nbr;
    typedef logic [NBR18_COUNT-1:0] t_nbr18;
    typedef logic [FACE_COUNT-1:0]  t_face;
    typedef logic [DIR_W-1:0]       t_dir;
    typedef logic [COUNT_W-1:0]     t_count;

    typedef struct packed {
        t_nbr   black;
        t_dir   dir;
        t_count count;
        t_nbr   reach_b;
        t_nbr18 reach_w;
    } t_work;

    // x: W -1 E +1, y: U -1 D +1, z: S -1 N +1
    localparam int OFF_X [NBR_COUNT] = '{
        0, 0, -1, 1, 0, 0,
        0, -1, 1, 0, -1, 1, -1, 1, 0, -1, 1, 0,
        -1, 1, -1, 1, -1, 1, -1, 1};
    localparam int OFF_Y [NBR_COUNT] = '{
        -1, 0, 0, 0, 0, 1,
        -1, -1, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1,
        -1, -1, -1, -1, 1, 1, 1, 1};
    localparam int OFF_Z [NBR_COUNT] = '{
        0, 1, 0, 0, -1, 0,
        1, 0, 0, -1, 1, 1, -1, -1, 1, 0, 0, -1,
        1, 1, -1, -1, 1, 1, -1, -1};

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // neighbours of position k: 26-adjacency when full26, else 6-adjacency
    function automatic t_nbr adj_mask(input int k, input bit full26);
        t_nbr m;
        int   dx;
        int   dy;
        int   dz;
        m = '0;
        for (int j = 0; j < NBR_COUNT; j++) begin
            dx = abs_diff(OFF_X[j], OFF_X[k]);
            dy = abs_diff(OFF_Y[j], OFF_Y[k]);
            dz = abs_diff(OFF_Z[j], OFF_Z[k]);
            if (j != k) begin
                if (full26) begin
                    if (dx <= 1 && dy <= 1 && dz <= 1) begin
                        m[j] = 1'b1;
                    end
                end else if (dx + dy + dz == 1) begin
                    m[j] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

@@ src/spt3d_if.sv @@
interface spt3d_in_if;
    logic                           valid;
    logic                           ready;
    logic [spt3d_pkg::NBR_COUNT-1:0] neighbour_bits;
    logic [spt3d_pkg::DIR_W-1:0]     border_direction;

    modport source (output valid, output neighbour_bits, output border_direction,
                    input ready);
    modport sink   (input valid, input neighbour_bits, input border_direction,
                    output ready);
endinterface

interface spt3d_out_if;
    logic                          valid;
    logic                          ready;
    logic                          deletable;
    logic                          is_simple_point;
    logic [spt3d_pkg::COUNT_W-1:0] black_count;

    modport source (output valid, output deletable, output is_simple_point,
                    output black_count, input ready);
    modport sink   (input valid, input deletable, input is_simple_point,
                    input black_count, output ready);
endinterface

@@ src/spt3d_front.sv @@
module spt3d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spt3d_in_if.sink          i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output spt3d_pkg::t_work  o_work
);
    import spt3d_pkg::*;

    logic   r_valid;
    t_work  r_work;
    t_work  n_work;
    t_face  white_faces;
    t_count cnt;

    always_comb begin
        cnt = '0;
        for (int k = 0; k < NBR_COUNT; k++) begin
            cnt = cnt + t_count'(i_in.neighbour_bits[k]);
        end
    end

    assign white_faces = ~i_in.neighbour_bits[FACE_COUNT-1:0];

    always_comb begin
        n_work         = '0;
        n_work.black   = i_in.neighbour_bits;
        n_work.dir     = i_in.border_direction;
        n_work.count   = cnt;
        // seeds: lowest black neighbour, lowest white face
        n_work.reach_b = i_in.neighbour_bits & (~i_in.neighbour_bits + t_nbr'(1));
        n_work.reach_w = t_nbr18'(white_faces & (~white_faces + t_face'(1)));
    end

    assign i_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

@@ src/spt3d_flood_stage.sv @@
module spt3d_flood_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spt3d_pkg::t_work  i_work,
    output logic              o_valid,
    input  logic              i_ready,
    output spt3d_pkg::t_work  o_work
);
    import spt3d_pkg::*;

    logic [FLOOD_STEPS:0][NBR_COUNT-1:0]   rb;
    logic [FLOOD_STEPS:0][NBR18_COUNT-1:0] rw;
    t_nbr18 white18;
    logic   r_valid;
    t_work  r_work;
    t_work  n_work;

    assign white18 = ~i_work.black[NBR18_COUNT-1:0];
    assign rb[0]   = i_work.reach_b;
    assign rw[0]   = i_work.reach_w;

    // each step adds every allowed node adjacent to the reached set
    for (genvar s = 0; s < FLOOD_STEPS; s++) begin : g_step
        for (genvar j = 0; j < NBR_COUNT; j++) begin : g_black
            localparam t_nbr M26 = adj_mask(j, 1'b1);
            assign rb[s+1][j] = i_work.black[j] & (rb[s][j] | (|(rb[s] & M26)));
        end
        for (genvar j = 0; j < NBR18_COUNT; j++) begin : g_white
            localparam t_nbr M6 = adj_mask(j, 1'b0);
            assign rw[s+1][j] = white18[j] &
                                (rw[s][j] | (|(rw[s] & M6[NBR18_COUNT-1:0])));
        end
    end

    always_comb begin
        n_work         = i_work;
        n_work.reach_b = rb[FLOOD_STEPS];
        n_work.reach_w = rw[FLOOD_STEPS];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

    a_black_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_work.reach_b & ~r_work.black) == '0))
        else $error("black reach left the black set");

    a_white_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_work.reach_w & r_work.black[NBR18_COUNT-1:0]) == '0))
        else $error("white reach entered a black voxel");

endmodule

@@ src/spt3d_decide.sv @@
module spt3d_decide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spt3d_pkg::t_work  i_work,
    spt3d_out_if.source       o_out
);
    import spt3d_pkg::*;

    logic       r_valid;
    logic       r_del;
    logic       r_simple;
    t_count     r_count;
    logic       n_del;
    logic       n_simple;
    t_face      white_faces;
    logic [7:0] face_white_ext;
    logic       cond_black;
    logic       cond_white;
    logic       border;

    assign white_faces    = ~i_work.black[FACE_COUNT-1:0];
    assign face_white_ext = {{(8 - FACE_COUNT){1'b0}}, white_faces};

    assign cond_black = (i_work.black != '0) && (i_work.reach_b == i_work.black);
    assign cond_white = (white_faces != '0) &&
                        (i_work.reach_w[FACE_COUNT-1:0] == white_faces);
    // direction codes six and seven land on the zero padding
    assign border     = face_white_ext[i_work.dir];
    assign n_simple   = cond_black && cond_white;
    assign n_del      = border && (i_work.count > t_count'(1)) && n_simple;

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_del    <= n_del;
            r_simple <= n_simple;
            r_count  <= i_work.count;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.deletable       = r_del;
    assign o_out.is_simple_point = r_simple;
    assign o_out.black_count     = r_count;

    a_del_simple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_del) |-> (r_simple && (r_count > t_count'(1))))
        else $error("deletable without simple point or with end point");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_count <= t_count'(NBR_COUNT)))
        else $error("black count out of range");

endmodule

@@ src/simple_point_test_3d.sv @@
// channel | dir | payload                                      | transfer
// i_in    | in  | neighbour_bits[25:0], border_direction[2:0]  | valid && ready
// o_out   | out | deletable, is_simple_point, black_count[4:0] | valid && ready
//
// one item per cycle sustained while o_out is ready; the input and the result are both registered
// the 7 flood stages (4 growth steps each) sit between the input and output registers
// synchronous active-low reset empties every stage; no other state
// each stage holds its item while the next one is full and stalled,
// so bubbles still close up behind a stalled output
module simple_point_test_3d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spt3d_in_if.sink     i_in,
    spt3d_out_if.source  o_out
);
    import spt3d_pkg::*;

    logic  st_valid [FLOOD_STAGES+1];
    logic  st_ready [FLOOD_STAGES+1];
    t_work st_work  [FLOOD_STAGES+1];

    spt3d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (st_valid[0]),
        .i_ready (st_ready[0]),
        .o_work  (st_work[0])
    );

    for (genvar s = 0; s < FLOOD_STAGES; s++) begin : g_flood
        spt3d_flood_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[s]),
            .o_ready (st_ready[s]),
            .i_work  (st_work[s]),
            .o_valid (st_valid[s+1]),
            .i_ready (st_ready[s+1]),
            .o_work  (st_work[s+1])
        );
    end

    spt3d_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[FLOOD_STAGES]),
        .o_ready (st_ready[FLOOD_STAGES]),
        .i_work  (st_work[FLOOD_STAGES]),
        .o_out   (o_out)
    );

endmodule

@@ tb/voxel_deletion_monitor.sv @@
module voxel_deletion_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    spt3d_in_if  i_in,
    spt3d_out_if i_out,
    output int   o_mismatch_count,
    output int   o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import spt3d_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic   deletable;
        logic   simple;
        t_count count;
    } t_voxel_verdict;

    // neighbour positions in the 3x3x3 cube: x west/east, y up/down, z south/north
    localparam int CUBE_X [NBR_COUNT] = '{
        0, 0, -1, 1, 0, 0,
        0, -1, 1, 0, -1, 1, -1, 1, 0, -1, 1, 0,
        -1, 1, -1, 1, -1, 1, -1, 1};
    localparam int CUBE_Y [NBR_COUNT] = '{
        -1, 0, 0, 0, 0, 1,
        -1, -1, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1,
        -1, -1, -1, -1, 1, 1, 1, 1};
    localparam int CUBE_Z [NBR_COUNT] = '{
        0, 1, 0, 0, -1, 0,
        1, 0, 0, -1, 1, 1, -1, -1, 1, 0, 0, -1,
        1, 1, -1, -1, 1, 1, -1, -1};

    t_nbr           touch26 [NBR_COUNT];
    t_nbr           touch6  [NBR_COUNT];
    t_voxel_verdict expected_verdicts [$];

    initial begin
        int dx;
        int dy;
        int dz;
        for (int k = 0; k < NBR_COUNT; k++) begin
            touch26[k] = '0;
            touch6[k]  = '0;
            for (int j = 0; j < NBR_COUNT; j++) begin
                dx = (CUBE_X[j] > CUBE_X[k]) ? CUBE_X[j] - CUBE_X[k] : CUBE_X[k] - CUBE_X[j];
                dy = (CUBE_Y[j] > CUBE_Y[k]) ? CUBE_Y[j] - CUBE_Y[k] : CUBE_Y[k] - CUBE_Y[j];
                dz = (CUBE_Z[j] > CUBE_Z[k]) ? CUBE_Z[j] - CUBE_Z[k] : CUBE_Z[k] - CUBE_Z[j];
                if (j != k && dx <= 1 && dy <= 1 && dz <= 1) begin
                    touch26[k][j] = 1'b1;
                end
                if (dx + dy + dz == 1) begin
                    touch6[k][j] = 1'b1;
                end
            end
        end
    end

    // region reachable from seed while staying inside allowed
    function automatic t_nbr grow_region(input t_nbr seed, input t_nbr allowed,
                                         input bit use26);
        t_nbr reach;
        t_nbr prev;
        reach = seed & allowed;
        prev  = '0;
        while (reach != prev) begin
            prev = reach;
            for (int k = 0; k < NBR_COUNT; k++) begin
                if (reach[k]) begin
                    reach |= (use26 ? touch26[k] : touch6[k]) & allowed;
                end
            end
        end
        return reach;
    endfunction

    function automatic t_voxel_verdict judge_voxel(input t_nbr black, input t_dir dir);
        t_voxel_verdict v;
        t_nbr           white18;
        t_nbr           white_faces;
        logic           black_ok;
        logic           white_ok;
        logic           border;
        white18     = ~black & t_nbr'((1 << NBR18_COUNT) - 1);
        white_faces = ~black & t_nbr'((1 << FACE_COUNT) - 1);
        v.count  = t_count'($countones(black));
        black_ok = (black != '0) &&
                   (grow_region(black & (~black + 1'b1), black, 1'b1) == black);
        white_ok = (white_faces != '0) &&
                   ((grow_region(white_faces & (~white_faces + 1'b1), white18, 1'b0)
                     & t_nbr'((1 << FACE_COUNT) - 1)) == white_faces);
        v.simple    = black_ok && white_ok;
        border      = (dir < FACE_COUNT) && !black[dir];
        v.deletable = border && (v.count > 1) && v.simple;
        return v;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_awaiting       = 0;
    end

    always @(posedge i_clk) begin
        t_voxel_verdict want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                expected_verdicts.insert(expected_verdicts.size(),
                                         judge_voxel(i_in.neighbour_bits,
                                                     i_in.border_direction));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_verdicts.size() == 0) begin
                    if (o_mismatch_count < MAX_REPORTS) begin
                        $display("%0t: unexpected verdict del=%b simple=%b count=%0d",
                                 $realtime, i_out.deletable, i_out.is_simple_point,
                                 i_out.black_count);
                    end
                    o_mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_out.deletable !== want.deletable ||
                        i_out.is_simple_point !== want.simple ||
                        i_out.black_count !== want.count) begin
                        if (o_mismatch_count < MAX_REPORTS) begin
                            $display({"%0t: verdict mismatch exp del=%b simple=%b ",
                                      "count=%0d, got del=%b simple=%b count=%0d"},
                                     $realtime, want.deletable, want.simple, want.count,
                                     i_out.deletable, i_out.is_simple_point,
                                     i_out.black_count);
                        end
                        o_mismatch_count++;
                    end
                end
            end
            o_awaiting = expected_verdicts.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spt3d_pkg::*;

    localparam int RANDOM_VOXELS = 700;
    localparam int LATENCY       = 9;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 150;
    localparam int FIRST_EDGE    = 6;
    localparam int FIRST_CORNER  = 18;

    typedef enum logic [DIR_W-1:0] {
        FACE_UP, FACE_NORTH, FACE_WEST, FACE_EAST, FACE_SOUTH, FACE_DOWN,
        NO_FACE_6, NO_FACE_7
    } t_face_dir;

    typedef struct {
        t_nbr      bits;
        t_face_dir dir;
    } t_probe;

    // handy neighbourhoods
    localparam t_nbr UPPER_PLANE  = 26'h03C03C1;
    localparam t_nbr MIDDLE_RING  = 26'h0003C1E;
    localparam t_nbr ALL_FACES    = 26'h000003F;
    localparam t_nbr ALL_BLACK    = 26'h3FFFFFF;

    logic   clk;
    logic   rst_n;
    int     mismatch_count;
    int     awaiting;
    int     rx_mode;
    t_probe probes [$];

    spt3d_in_if  voxel_in ();
    spt3d_out_if verdict_out ();

    simple_point_test_3d dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (voxel_in),
        .o_out  (verdict_out)
    );

    voxel_deletion_monitor deletion_mon (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in            (voxel_in),
        .i_out           (verdict_out),
        .o_mismatch_count(mismatch_count),
        .o_awaiting      (awaiting)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // mode 0 never idles, mode 1 short idles, mode 2 mixes in long ones
    function automatic int gap_length(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0) begin
            return 0;
        end else if (mode == 1) begin
            return (roll < 60) ? 0 : $urandom_range(1, 3);
        end else begin
            if (roll < 50) return 0;
            if (roll < 90) return $urandom_range(1, 4);
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic t_nbr random_neighbourhood();
        t_nbr bits;
        int   density;
        case ($urandom_range(0, 4))
            0: density = 5;
            1: density = 25;
            2: density = 50;
            3: density = 75;
            default: density = 95;
        endcase
        for (int k = 0; k < NBR_COUNT; k++) begin
            bits[k] = ($urandom_range(0, 99) < density);
        end
        return bits;
    endfunction

    task automatic add_probe(input t_nbr bits, input t_face_dir dir);
        t_probe p;
        p.bits = bits;
        p.dir  = dir;
        probes.insert(probes.size(), p);
    endtask

    // valid stays high after the transfer; the caller lowers it for a gap and after the last voxel
    task automatic offer_voxel(input t_nbr bits, input t_dir dir);
        voxel_in.valid            <= 1'b1;
        voxel_in.neighbour_bits   <= bits;
        voxel_in.border_direction <= dir;
        do @(posedge clk); while (!voxel_in.ready);
    endtask

    task automatic sender_gap(input int mode);
        int gap;
        gap = gap_length(mode);
        if (gap > 0) begin
            voxel_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // output side: random stalls plus one long hold while the input keeps coming
    initial begin
        int  cycles;
        int  stall;
        bit  held;
        cycles  = 0;
        held    = 1'b0;
        rx_mode = 0;
        verdict_out.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!held && cycles >= HOLD_START) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else begin
                stall = gap_length(rx_mode);
            end
            if (stall > 0) begin
                verdict_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                cycles += stall;
            end
            verdict_out.ready <= 1'b1;
            @(posedge clk);
            cycles++;
            if (cycles % 128 == 0) begin
                rx_mode = $urandom_range(0, 2);
            end
        end
    end

    initial begin
        int        tx_mode;
        t_face_dir dir;
        rst_n                     <= 1'b0;
        voxel_in.valid            <= 1'b0;
        voxel_in.neighbour_bits   <= '0;
        voxel_in.border_direction <= '0;
        tx_mode = 0;

        add_probe(26'h0, FACE_UP);                     // nothing black
        add_probe(ALL_BLACK, FACE_UP);                 // no white face
        add_probe(26'h1, FACE_DOWN);                   // lone face: end point
        add_probe(t_nbr'(1) << FIRST_EDGE, FACE_UP);   // lone edge
        add_probe(t_nbr'(1) << (NBR_COUNT - 1), FACE_WEST); // lone corner
        add_probe(t_nbr'(1) << FIRST_CORNER, FACE_EAST);
        add_probe(26'h3, FACE_DOWN);                   // two touching faces
        add_probe(26'h21, FACE_WEST);                  // up and down apart
        add_probe(UPPER_PLANE, FACE_DOWN);
        add_probe(UPPER_PLANE, FACE_UP);               // chosen face black
        add_probe(UPPER_PLANE, NO_FACE_6);
        add_probe(UPPER_PLANE, NO_FACE_7);
        add_probe(ALL_BLACK & ~t_nbr'(1 << FACE_WEST), FACE_WEST);
        add_probe(ALL_BLACK & ~ALL_FACES, FACE_NORTH); // white faces isolated
        add_probe(ALL_FACES, FACE_SOUTH);
        add_probe(MIDDLE_RING, FACE_UP);               // tunnel through the ring
        add_probe(26'h2AAAAAA, FACE_EAST);
        add_probe(26'h1555555, FACE_SOUTH);
        add_probe(ALL_BLACK & ~t_nbr'(1 << FACE_DOWN), FACE_DOWN);
        add_probe(26'h0, NO_FACE_7);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i]) begin
            offer_voxel(probes[i].bits, probes[i].dir);
            sender_gap(i % 3);
        end

        for (int n = 0; n < RANDOM_VOXELS; n++) begin
            if (n % 64 == 0) begin
                tx_mode = $urandom_range(0, 2);
            end
            if ($urandom_range(0, 9) < 9) begin
                dir = t_face_dir'($urandom_range(FACE_UP, FACE_DOWN));
            end else begin
                dir = t_face_dir'($urandom_range(NO_FACE_6, NO_FACE_7));
            end
            offer_voxel(random_neighbourhood(), dir);
            sender_gap(tx_mode);
        end
        voxel_in.valid <= 1'b0;

        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (mismatch_count == 0 && awaiting == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/spt3d_pkg.sv
src/spt3d_if.sv
src/spt3d_front.sv
src/spt3d_flood_stage.sv
src/spt3d_decide.sv
src/simple_point_test_3d.sv
tb/voxel_deletion_monitor.sv
tb/testbench.sv
